@@ hdl/prq_pkg.sv @@
// Package for the priority ready-queue scheduler: widths, action and status codes,
// the lowest priority and the result word type. No dependencies.
`default_nettype none
package prq_pkg;
  localparam int Levels = 32;
  localparam int Slots  = 16;
  localparam int PW = 5;
  localparam int TW = 4;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_REMOVE   = 2'd1;
  localparam logic [1:0] ACT_SCHEDULE = 2'd2;
  localparam logic [1:0] ACT_START    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_DUP    = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam logic [PW-1:0] LowestPrio = PW'(Levels - 1);

  typedef struct packed {
    logic [1:0]    status;
    logic          switch_now;
    logic          from_valid;
    logic [TW-1:0] old_thread;
    logic [TW-1:0] next_thread;
    logic [PW-1:0] chosen_priority;
  } result_t;
endpackage
`default_nettype wire

@@ hdl/prq_ffs.sv @@
// Find-first-set over the ready bitmap, one level per cycle on a shared compare.
// Depends on prq_pkg.
`default_nettype none
module prq_ffs (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic [prq_pkg::Levels-1:0] bitmap,
  output logic                          done,
  output logic                          found,
  output logic [prq_pkg::PW-1:0]        level
);
  logic busy;
  logic [prq_pkg::PW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      found <= 1'b0;
      idx <= '0;
      level <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (busy) begin
        // advance until a set bit or the last level
        if (bitmap[idx]) begin
          busy <= 1'b0;
          done <= 1'b1;
          found <= 1'b1;
          level <= idx;
        end else if (idx == prq_pkg::LowestPrio) begin
          busy <= 1'b0;
          done <= 1'b1;
          found <= 1'b0;
          level <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("ffs done held");
  a_found_set: assert property (@(posedge clk) disable iff (rst)
    (busy && !go && bitmap[idx]) |=> (found && done))
    else $error("ffs missed set bit");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("ffs busy after done");
endmodule
`default_nettype wire

@@ hdl/priority_ready_queue_scheduler_top.sv @@
// Top level of the priority ready-queue scheduler: list storage, link sequencer,
// output register. Depends on prq_pkg and prq_ffs.
//
// Usage: one input word on (action, thread_id, priority_req) with valid/stall
// gives exactly one result word on the output channel. Insert and remove update
// the head/tail/link registers in one sequencer step, S_EXEC, which registers
// the result; the word is then shown in S_OUT.
// Schedule and start run the find-first-set unit, which tests one level per
// cycle; the sequencer passes S_FFS and S_WAIT, registers the result when the
// unit is done and shows it in S_OUT.
// The input channel stalls while a word is in work and while the result still
// waits in the output register; a stalled result holds its value.
// Reset clears the bitmap, queued flags, running state (priority 31) and the
// sequencer; heads, tails and links hold no reset value and are read only
// while their list holds the slot.
`default_nettype none
module priority_ready_queue_scheduler_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] action,
  input  wire logic [3:0] thread_id,
  input  wire logic [4:0] priority_req,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic            switch_now,
  output logic            from_valid,
  output logic [3:0]      old_thread,
  output logic [3:0]      next_thread,
  output logic [4:0]      chosen_priority
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FFS  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [1:0] act;
  logic [3:0] tid;
  logic [4:0] preq;
  logic [prq_pkg::Levels-1:0] ready_bitmap;
  logic [3:0] list_head [prq_pkg::Levels];
  logic [3:0] list_tail [prq_pkg::Levels];
  logic [3:0] next_link [prq_pkg::Slots];
  logic [3:0] prev_link [prq_pkg::Slots];
  logic [4:0] slot_priority [prq_pkg::Slots];
  logic [prq_pkg::Slots-1:0] queued_flag;
  logic [3:0] running_thread;
  logic       running_valid;
  logic [4:0] running_priority;
  prq_pkg::result_t res;
  prq_pkg::result_t res_next;

  logic ffs_go, ffs_done, ffs_found;
  logic [4:0] ffs_level;

  prq_ffs u_ffs (
    .clk(clk), .rst(rst), .go(ffs_go), .bitmap(ready_bitmap),
    .done(ffs_done), .found(ffs_found), .level(ffs_level)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign ffs_go    = (state == S_FFS);
  assign status          = res.status;
  assign switch_now      = res.switch_now;
  assign from_valid      = res.from_valid;
  assign old_thread      = res.old_thread;
  assign next_thread     = res.next_thread;
  assign chosen_priority = res.chosen_priority;

  // list operation values
  logic [4:0] rp;
  logic [3:0] nx, pv, hd, to;
  logic is_head, is_tail;
  logic do_switch;
  always_comb begin
    rp = slot_priority[tid];
    nx = next_link[tid];
    pv = prev_link[tid];
    is_head = (list_head[rp] == tid);
    is_tail = (list_tail[rp] == tid);
    hd = list_tail[preq];
    to = list_head[ffs_level];
    do_switch = !(act == prq_pkg::ACT_SCHEDULE && running_valid && running_thread == to);
  end

  // result word for the list step or the find-first-set step
  always_comb begin
    res_next = '0;
    if (state == S_EXEC) begin
      if (act == prq_pkg::ACT_INSERT)
        res_next.status = queued_flag[tid] ? prq_pkg::ST_DUP : prq_pkg::ST_OK;
      else
        res_next.status = queued_flag[tid] ? prq_pkg::ST_OK : prq_pkg::ST_ABSENT;
    end else if (!ffs_found) begin
      res_next.status = prq_pkg::ST_EMPTY;
    end else begin
      res_next.status = prq_pkg::ST_OK;
      res_next.next_thread = to;
      res_next.chosen_priority = ffs_level;
      if (do_switch) begin
        res_next.switch_now = 1'b1;
        if (act == prq_pkg::ACT_SCHEDULE) begin
          res_next.from_valid = running_valid;
          res_next.old_thread = running_valid ? running_thread : 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready_bitmap <= '0;
      queued_flag <= '0;
      running_thread <= '0;
      running_valid <= 1'b0;
      running_priority <= prq_pkg::LowestPrio;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            tid <= thread_id;
            preq <= priority_req;
            state <= (action[1]) ? S_FFS : S_EXEC;
          end
        end
        S_EXEC: begin
          res <= res_next;
          if (act == prq_pkg::ACT_INSERT) begin
            if (!queued_flag[tid]) begin
              if (ready_bitmap[preq]) begin
                next_link[hd] <= tid;
                prev_link[tid] <= hd;
              end else begin
                list_head[preq] <= tid;
                prev_link[tid] <= tid;
              end
              next_link[tid] <= tid;
              list_tail[preq] <= tid;
              slot_priority[tid] <= preq;
              queued_flag[tid] <= 1'b1;
              ready_bitmap[preq] <= 1'b1;
            end
          end else begin
            if (queued_flag[tid]) begin
              if (is_head && is_tail) begin
                ready_bitmap[rp] <= 1'b0;
              end else begin
                // unlink; in the tail case pv becomes the tail and links to itself
                if (is_head) list_head[rp] <= nx;
                else if (!is_tail) next_link[pv] <= nx;
                if (is_tail) begin
                  list_tail[rp] <= pv;
                  next_link[pv] <= pv;
                end else begin
                  prev_link[nx] <= is_head ? nx : pv;
                end
              end
              queued_flag[tid] <= 1'b0;
            end
          end
          state <= S_OUT;
        end
        S_FFS: state <= S_WAIT;
        S_WAIT: begin
          if (ffs_done) begin
            res <= res_next;
            state <= S_OUT;
            if (ffs_found && do_switch) begin
              running_thread <= to;
              running_valid <= 1'b1;
              running_priority <= ffs_level;
            end
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(res)))
    else $error("result changed under stall");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("ready while busy");
  a_run_prio: assert property (@(posedge clk) disable iff (rst)
    (switch_now && out_valid) |-> (running_priority == chosen_priority))
    else $error("running priority mismatch");
endmodule
`default_nettype wire
